// ===== hdl/pol_pkg.sv =====
// ----------------------------------------------------------------------------
// pol_pkg
// Shared types for the positional ordered list: request modes, result status
// codes and the command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package pol_pkg;

    typedef enum logic [1:0] {
        MODE_INS = 2'd0,
        MODE_DEL = 2'd1,
        MODE_RET = 2'd2,
        MODE_LOC = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BADPOS   = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    typedef struct packed {
        logic load;
        logic walk;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic walk_done;
        logic err;
    } t_dp_sts;

endpackage

// ===== hdl/pol_ctrl.sv =====
// ----------------------------------------------------------------------------
// pol_ctrl
// Controller: takes a request, runs the datapath walk until it drains, then
// commits the request and raises the result strobe for one cycle.
// ----------------------------------------------------------------------------
module pol_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    output logic             o_busy,
    input  pol_pkg::t_dp_sts i_sts,
    output pol_pkg::t_cmd    o_cmd,
    output logic             o_res_valid
);
    import pol_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_FIN
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_res_valid;

    always_comb begin
        n_state      = r_state;
        o_cmd.load   = 1'b0;
        o_cmd.walk   = 1'b0;
        o_cmd.finish = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_WALK;
                end
            end
            S_WALK: begin
                o_cmd.walk = 1'b1;
                if (i_sts.walk_done || i_sts.err) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                o_cmd.finish = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_res_valid <= (r_state == S_FIN);
        end
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_res_valid = r_res_valid;

endmodule

// ===== hdl/pol_datapath.sv =====
// ----------------------------------------------------------------------------
// pol_datapath
// Entry memory with one write and one registered read port, count and limit
// registers, request checks, and a walk pointer that moves one entry a cycle.
// ----------------------------------------------------------------------------
module pol_datapath #(
    parameter int CAPACITY = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  pol_pkg::t_cmd        i_cmd,
    output pol_pkg::t_dp_sts     o_sts,
    input  logic [1:0]           i_mode,
    input  logic [5:0]           i_position,
    input  logic signed [31:0]   i_value_in,
    input  logic                 i_cfg_we,
    input  logic [5:0]           i_cfg_data,
    output logic signed [31:0]   o_value_out,
    output logic [5:0]           o_found_position,
    output logic [1:0]           o_status,
    output logic [5:0]           o_length,
    output logic                 o_empty_res
);
    import pol_pkg::*;

    localparam int         AW      = $clog2(CAPACITY);
    localparam int         IW      = (AW > 6) ? AW : 6;
    localparam logic [5:0] CAP_LIM = (CAPACITY > 63) ? 6'd63 : 6'(CAPACITY);

    function automatic logic [AW-1:0] to_addr(input logic [5:0] idx);
        logic [IW-1:0] w;
        w = IW'(idx);
        return w[AW-1:0];
    endfunction

    logic [31:0] r_mem [CAPACITY];
    logic [31:0] r_rd;

    logic [5:0]  r_count;
    logic [5:0]  n_count;
    logic [5:0]  r_limit;
    logic [5:0]  lim;
    t_mode       r_mode;
    logic [5:0]  r_pos;
    logic [31:0] r_val;
    logic        r_err;
    t_status     r_status;
    logic [5:0]  r_ptr;
    logic [5:0]  r_raddr;
    logic        r_rvld;
    logic        r_hit;
    logic [31:0] r_vout;
    logic [5:0]  r_found;

    logic signed [31:0] r_o_vout;
    logic [5:0]         r_o_found;
    t_status            r_o_status;
    logic [5:0]         r_o_len;
    logic               r_o_empty;

    logic        ld_err;
    t_status     ld_status;
    logic [5:0]  ld_ptr;
    logic        go;
    logic        rd_go;
    logic [5:0]  rd_idx;
    logic        wr_en;
    logic [5:0]  wr_idx;
    logic [31:0] wr_data;
    logic        hit_now;
    logic        cap_vout;

    assign lim = (r_limit < CAP_LIM) ? r_limit : CAP_LIM;

    always_comb begin
        ld_err    = 1'b0;
        ld_status = ST_OK;
        ld_ptr    = 6'd0;
        case (t_mode'(i_mode))
            MODE_INS: begin
                ld_ptr = r_count;
                if (i_position > r_count) begin
                    ld_err    = 1'b1;
                    ld_status = ST_BADPOS;
                end else if (r_count >= lim) begin
                    ld_err    = 1'b1;
                    ld_status = ST_FULL;
                end
            end
            MODE_DEL, MODE_RET: begin
                ld_ptr = i_position - 6'd1;
                if (i_position == 6'd0 || i_position > r_count) begin
                    ld_err    = 1'b1;
                    ld_status = ST_BADPOS;
                end
            end
            MODE_LOC: begin
                ld_status = ST_NOTFOUND;
            end
            default: begin
                ld_status = ST_NOTFOUND;
            end
        endcase
    end

    always_comb begin
        go     = 1'b0;
        rd_idx = r_ptr;
        case (r_mode)
            MODE_INS: begin
                go     = (r_ptr > r_pos);
                rd_idx = r_ptr - 6'd1;
            end
            MODE_DEL: go = (r_ptr < r_count);
            MODE_RET: go = (r_ptr < r_pos);
            MODE_LOC: go = (r_ptr < r_count) && !r_hit;
            default:  go = 1'b0;
        endcase
    end

    assign rd_go           = go && i_cmd.walk && !r_err;
    assign o_sts.walk_done = !rd_go && !r_rvld;
    assign o_sts.err       = r_err;

    assign hit_now  = r_rvld && (r_mode == MODE_LOC) && !r_hit && (r_rd == r_val);
    assign cap_vout = r_rvld && ((r_mode == MODE_RET) ||
                      ((r_mode == MODE_DEL) && (r_raddr == r_pos - 6'd1)));

    always_comb begin
        wr_en   = 1'b0;
        wr_idx  = r_pos;
        wr_data = r_val;
        if (i_cmd.finish && (r_mode == MODE_INS) && !r_err) begin
            wr_en = 1'b1;
        end else if (r_rvld && (r_mode == MODE_INS)) begin
            wr_en   = 1'b1;
            wr_idx  = r_raddr + 6'd1;
            wr_data = r_rd;
        end else if (r_rvld && (r_mode == MODE_DEL) && (r_raddr != r_pos - 6'd1)) begin
            wr_en   = 1'b1;
            wr_idx  = r_raddr - 6'd1;
            wr_data = r_rd;
        end
    end

    always_comb begin
        n_count = r_count;
        if (i_cmd.finish && !r_err) begin
            if (r_mode == MODE_INS) begin
                n_count = r_count + 6'd1;
            end else if (r_mode == MODE_DEL) begin
                n_count = r_count - 6'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[to_addr(wr_idx)] <= wr_data;
        end
        if (rd_go) begin
            r_rd <= r_mem[to_addr(rd_idx)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= 6'd0;
            r_limit  <= 6'd32;
            r_rvld   <= 1'b0;
            r_hit    <= 1'b0;
            r_mode   <= MODE_INS;
            r_err    <= 1'b0;
            r_status <= ST_OK;
            r_ptr    <= 6'd0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_data;
            end
            r_count <= n_count;
            r_rvld  <= rd_go;
            if (i_cmd.load) begin
                r_hit    <= 1'b0;
                r_mode   <= t_mode'(i_mode);
                r_err    <= ld_err;
                r_status <= ld_status;
                r_ptr    <= ld_ptr;
            end else begin
                if (hit_now) begin
                    r_hit    <= 1'b1;
                    r_status <= ST_OK;
                end
                if (rd_go) begin
                    r_ptr <= (r_mode == MODE_INS) ? r_ptr - 6'd1 : r_ptr + 6'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_pos   <= i_position;
            r_val   <= i_value_in;
            r_vout  <= 32'd0;
            r_found <= 6'd0;
        end else begin
            if (cap_vout) begin
                r_vout <= r_rd;
            end
            if (hit_now) begin
                r_found <= r_raddr + 6'd1;
            end
        end
        if (rd_go) begin
            r_raddr <= rd_idx;
        end
        if (i_cmd.finish) begin
            r_o_vout   <= r_vout;
            r_o_found  <= r_found;
            r_o_status <= r_status;
            r_o_len    <= n_count;
            r_o_empty  <= (n_count == 6'd0);
        end
    end

    assign o_value_out      = r_o_vout;
    assign o_found_position = r_o_found;
    assign o_status         = r_o_status;
    assign o_length         = r_o_len;
    assign o_empty_res      = r_o_empty;

endmodule

// ===== hdl/positional_ordered_list.sv =====
// ----------------------------------------------------------------------------
// positional_ordered_list
// Ordered list of signed 32-bit values with insert, delete and retrieve by
// position and locate by value, each request answered by one result item.
// ----------------------------------------------------------------------------
// channel   | handshake                 | payload
// ----------+---------------------------+-------------------------------------
// request   | start, busy               | i_mode, i_position, i_value_in
// result    | o_res_valid (1 cycle)     | o_value_out, o_found_position,
//           |                           | o_status, o_length, o_empty_res
// config    | i_cfg_valid, o_cfg_ready  | i_cfg_data (size limit)
//
// One item at a time. Insert and delete walk the entries from the position to
// the end of the list, retrieve reads one entry, locate walks until a match or
// the end; a rejected request, an insert at the end or a locate on an empty
// list does no walk. The walk over the entry memory does one read per cycle.
// Synchronous reset clears the count and sets the size limit to 32; entries
// stay undefined until written, with no clearing pass.
// The result strobe lasts one cycle; the receiver cannot stall it.
// ----------------------------------------------------------------------------
module positional_ordered_list #(
    parameter int CAPACITY = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_mode,
    input  logic [5:0]         i_position,
    input  logic signed [31:0] i_value_in,
    output logic               o_res_valid,
    output logic signed [31:0] o_value_out,
    output logic [5:0]         o_found_position,
    output logic [1:0]         o_status,
    output logic [5:0]         o_length,
    output logic               o_empty_res,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [5:0]         i_cfg_data
);
    import pol_pkg::*;

    t_cmd    cmd;
    t_dp_sts sts;

    assign o_cfg_ready = 1'b1;

    pol_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .o_busy      (busy),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_res_valid (o_res_valid)
    );

    pol_datapath #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_mode           (i_mode),
        .i_position       (i_position),
        .i_value_in       (i_value_in),
        .i_cfg_we         (i_cfg_valid && o_cfg_ready),
        .i_cfg_data       (i_cfg_data),
        .o_value_out      (o_value_out),
        .o_found_position (o_found_position),
        .o_status         (o_status),
        .o_length         (o_length),
        .o_empty_res      (o_empty_res)
    );

    a_strobe_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |=> !o_res_valid)
        else $error("result strobe held longer than one cycle");

    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

    a_empty_matches_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> (o_empty_res == (o_length == 6'd0)))
        else $error("empty flag disagrees with length");

    a_error_zero_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> ((o_status == ST_OK) || (o_value_out == 32'sd0)))
        else $error("nonzero value returned with error status");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the positional ordered list. A clocked driver sends
// queued requests over the start/busy handshake and updates a shadow list
// model on each accepted item. A clocked monitor compares every result strobe,
// field by field, with the oldest predicted result. Phases sweep the size
// limit, including zero, one and values past the capacity, under varied
// sender idling.
// ----------------------------------------------------------------------------
module tb_top;
    import pol_pkg::*;

    localparam int CAPACITY    = 32;
    localparam int CYCLE_LIMIT = 600000;
    localparam int PHASE_ITEMS = 128;
    localparam int NUM_PHASES  = 9;

    typedef struct packed {
        t_mode              mode;
        logic [5:0]         position;
        logic signed [31:0] value;
    } t_list_cmd;

    typedef struct packed {
        logic signed [31:0] value_out;
        logic [5:0]         found_position;
        t_status            status;
        logic [5:0]         length;
        logic               empty_res;
    } t_list_result;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [1:0]         i_mode = MODE_INS;
    logic [5:0]         i_position = '0;
    logic signed [31:0] i_value_in = '0;
    logic               o_res_valid;
    logic signed [31:0] o_value_out;
    logic [5:0]         o_found_position;
    logic [1:0]         o_status;
    logic [5:0]         o_length;
    logic               o_empty_res;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [5:0]         i_cfg_data = '0;

    t_list_cmd    pending_q[$];
    t_list_result list_result_q[$];
    t_list_cmd    next_cmd;
    t_list_result got_result;
    t_list_result want_result;

    logic signed [31:0] list_mem [CAPACITY];
    int                 list_count = 0;
    logic [5:0]         size_limit_reg = 6'd32;

    logic [31:0] planned_vals[$];
    int          plan_limit = CAPACITY;
    bit          fill_bias = 1'b1;

    int idle_pct = 20;
    int err_count = 0;
    int cycle_count = 0;

    positional_ordered_list #(.CAPACITY(CAPACITY)) i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_mode           (i_mode),
        .i_position       (i_position),
        .i_value_in       (i_value_in),
        .o_res_valid      (o_res_valid),
        .o_value_out      (o_value_out),
        .o_found_position (o_found_position),
        .o_status         (o_status),
        .o_length         (o_length),
        .o_empty_res      (o_empty_res),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (err_count < 100) begin
            $display("tb_top: mismatch on %s: got %h, want %h", what, got, want);
        end
        err_count++;
    endtask

    task automatic apply_list_request(input t_mode mode, input logic [5:0] pos,
                                      input logic signed [31:0] val);
        t_list_result r;
        int           lim;
        int           i;
        lim = (size_limit_reg < CAPACITY) ? size_limit_reg : CAPACITY;
        r = '0;
        r.status = ST_OK;
        case (mode)
            MODE_INS: begin
                if (pos > list_count) begin
                    r.status = ST_BADPOS;
                end else if (list_count >= lim) begin
                    r.status = ST_FULL;
                end else begin
                    for (i = list_count; i > pos; i--) list_mem[i] = list_mem[i - 1];
                    list_mem[pos] = val;
                    list_count++;
                end
            end
            MODE_DEL: begin
                if (pos < 1 || pos > list_count) begin
                    r.status = ST_BADPOS;
                end else begin
                    r.value_out = list_mem[pos - 1];
                    for (i = pos; i < list_count; i++) list_mem[i - 1] = list_mem[i];
                    list_count--;
                end
            end
            MODE_RET: begin
                if (pos < 1 || pos > list_count) r.status = ST_BADPOS;
                else r.value_out = list_mem[pos - 1];
            end
            default: begin
                r.status = ST_NOTFOUND;
                for (i = 0; i < list_count; i++) begin
                    if (list_mem[i] == val) begin
                        r.found_position = 6'(i + 1);
                        r.status = ST_OK;
                        break;
                    end
                end
            end
        endcase
        r.length = list_count[5:0];
        r.empty_res = (list_count == 0);
        list_result_q.push_back(r);
    endtask

    // hold the item until busy drops, then advance or idle
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                apply_list_request(t_mode'(i_mode), i_position, i_value_in);
            end
            if (!start || !busy) begin
                if (pending_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
                    next_cmd = pending_q.pop_front();
                    start <= 1'b1;
                    i_mode <= next_cmd.mode;
                    i_position <= next_cmd.position;
                    i_value_in <= next_cmd.value;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_res_valid === 1'b1) begin
            got_result = '{o_value_out, o_found_position, t_status'(o_status),
                           o_length, o_empty_res};
            if (list_result_q.size() == 0) begin
                report_mismatch("unexpected result", got_result.value_out, '0);
            end else begin
                want_result = list_result_q.pop_front();
                if (got_result.value_out !== want_result.value_out)
                    report_mismatch("value_out", got_result.value_out,
                                    want_result.value_out);
                if (got_result.found_position !== want_result.found_position)
                    report_mismatch("found_position", 32'(got_result.found_position),
                                    32'(want_result.found_position));
                if (got_result.status !== want_result.status)
                    report_mismatch("status", 32'(got_result.status),
                                    32'(want_result.status));
                if (got_result.length !== want_result.length)
                    report_mismatch("length", 32'(got_result.length),
                                    32'(want_result.length));
                if (got_result.empty_res !== want_result.empty_res)
                    report_mismatch("empty_res", 32'(got_result.empty_res),
                                    32'(want_result.empty_res));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    task automatic queue_item(input t_mode m, input logic [5:0] p, input logic [31:0] v);
        int n;
        n = planned_vals.size();
        if (m == MODE_INS && p <= n && n < plan_limit) planned_vals.insert(p, v);
        else if (m == MODE_DEL && p >= 1 && p <= n) planned_vals.delete(p - 1);
        pending_q.push_back('{m, p, v});
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(7))
            0, 1: return $urandom_range(7);
            2: begin
                case ($urandom_range(2))
                    0: return 32'h8000_0000;
                    1: return 32'h7fff_ffff;
                    default: return 32'hffff_ffff;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    task automatic gen_random_item();
        int         n;
        int         roll;
        int         ins_w;
        logic [5:0] p;
        logic [31:0] v;
        n = planned_vals.size();
        roll = $urandom_range(99);
        ins_w = fill_bias ? 50 : 20;
        v = pick_value();
        if ($urandom_range(39) == 0) fill_bias = !fill_bias;
        if (roll < 12) begin
            queue_item(t_mode'($urandom_range(3)), 6'($urandom_range(63)), v);
        end else if (roll < 12 + ins_w) begin
            p = ($urandom_range(3) == 0) ? 6'(n) : 6'($urandom_range(n));
            queue_item(MODE_INS, p, v);
        end else begin
            p = (n == 0) ? 6'd1 : 6'($urandom_range(n, 1));
            case ($urandom_range(2))
                0: queue_item(MODE_DEL, p, v);
                1: queue_item(MODE_RET, p, v);
                default: begin
                    if (n != 0 && $urandom_range(2) != 0) v = planned_vals[$urandom_range(n - 1)];
                    queue_item(MODE_LOC, 6'($urandom_range(63)), v);
                end
            endcase
        end
    endtask

    task automatic wait_list_idle();
        while (pending_q.size() != 0 || list_result_q.size() != 0 || start)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_size_limit(input logic [5:0] v);
        wait_list_idle();
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        i_cfg_valid <= 1'b0;
        size_limit_reg = v;
        plan_limit = (v < CAPACITY) ? v : CAPACITY;
    endtask

    initial begin
        int limits[NUM_PHASES];
        int ph;
        int k;
        limits = '{1, 0, 63, 32, 12, 33, 2, 32, 5};
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        write_size_limit(6'd32);
        idle_pct = 20;
        queue_item(MODE_RET, 6'd1, 32'd0);
        queue_item(MODE_DEL, 6'd0, 32'd0);
        queue_item(MODE_LOC, 6'd0, 32'd0);
        queue_item(MODE_INS, 6'd1, 32'd9);
        queue_item(MODE_INS, 6'd0, 32'h7fff_ffff);
        queue_item(MODE_INS, 6'd0, 32'h8000_0000);
        queue_item(MODE_INS, 6'd2, 32'hffff_ffff);
        queue_item(MODE_INS, 6'd1, 32'd0);
        queue_item(MODE_INS, 6'd63, 32'd5);
        for (k = 1; k <= 4; k++) queue_item(MODE_RET, 6'(k), 32'd0);
        queue_item(MODE_RET, 6'd5, 32'd0);
        queue_item(MODE_RET, 6'd0, 32'd0);
        queue_item(MODE_RET, 6'd63, 32'hffff_ffff);
        queue_item(MODE_LOC, 6'd0, 32'hffff_ffff);
        queue_item(MODE_LOC, 6'd63, 32'h8000_0000);
        queue_item(MODE_LOC, 6'd0, 32'd5);
        queue_item(MODE_INS, 6'd4, 32'h7fff_ffff);
        queue_item(MODE_LOC, 6'd0, 32'h7fff_ffff);
        queue_item(MODE_DEL, 6'd6, 32'd0);
        queue_item(MODE_DEL, 6'd5, 32'd0);
        queue_item(MODE_DEL, 6'd1, 32'd0);
        queue_item(MODE_DEL, 6'd3, 32'd0);
        queue_item(MODE_LOC, 6'd0, 32'd0);

        for (ph = 0; ph < NUM_PHASES; ph++) begin
            write_size_limit((ph == 4) ? 6'($urandom_range(63)) : 6'(limits[ph]));
            idle_pct = (ph < 3) ? 20 : (ph < 6) ? 78 : 0;
            fill_bias = 1'($urandom_range(1));
            for (k = 0; k < PHASE_ITEMS; k++) gen_random_item();
        end

        wait_list_idle();
        repeat (20) @(posedge i_clk);
        if (err_count == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule
